>>> src/rcrb_pkg.sv
`default_nettype none
package rcrb_pkg;

  typedef enum logic [3:0] {
    ACT_ADD    = 4'd0,
    ACT_ADDI   = 4'd1,
    ACT_SUB    = 4'd2,
    ACT_MUL    = 4'd3,
    ACT_BEQ    = 4'd4,
    ACT_BNE    = 4'd5,
    ACT_SLT    = 4'd6,
    ACT_J      = 4'd7,
    ACT_LW     = 4'd8,
    ACT_SW     = 4'd9,
    ACT_LABEL  = 4'd10,
    ACT_FINISH = 4'd11
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_REG  = 2'd1,
    ST_NO_LABEL  = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_ROW_DELAY  = 2'd0,
    CFG_COL_DELAY  = 2'd1,
    CFG_PROG_LEN   = 2'd2
  } cfg_idx_e;

  localparam int unsigned REG_AW   = 5;
  localparam int unsigned NUM_REGS = 32;
  localparam logic [REG_AW-1:0] ZERO_REG = 5'd31;
  localparam int unsigned DELAY_W  = 10;
  localparam int unsigned PLEN_W   = 17;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned PC_W     = 16;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [31:0]       data;
  } rf_wr_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr_a;
    logic [REG_AW-1:0] addr_b;
  } rf_rd_t;

endpackage
`default_nettype wire

>>> src/rcrb_if.sv
`default_nettype none
interface rcrb_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic [4:0]         dest_reg;
  logic signed [31:0] operand_b;
  logic signed [31:0] operand_c;
  logic               use_register;
  logic [15:0]        target_index;
  logic               target_defined;

  modport source (output valid, action, dest_reg, operand_b, operand_c, use_register,
                  target_index, target_defined, input ready);
  modport sink (input valid, action, dest_reg, operand_b, operand_c, use_register,
                target_index, target_defined, output ready);
endinterface

interface rcrb_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        next_pc;
  logic signed [31:0] dest_value;
  logic [31:0]        cycles_total;
  logic [31:0]        row_updates;

  modport source (output valid, status, next_pc, dest_value, cycles_total, row_updates,
                  input ready);
  modport sink (input valid, status, next_pc, dest_value, cycles_total, row_updates,
                output ready);
endinterface
`default_nettype wire

>>> src/rcrb_regfile.sv
`default_nettype none
module rcrb_regfile (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rcrb_pkg::rf_rd_t rd_i,
  input  wire rcrb_pkg::rf_wr_t wr_i,
  output logic [31:0]          rd_a_o,
  output logic [31:0]          rd_b_o
);

  logic [31:0] mem [rcrb_pkg::NUM_REGS];
  logic [rcrb_pkg::NUM_REGS-1:0] vld_q;
  logic [31:0] data_a_q, data_b_q;
  logic        ok_a_q, ok_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_a_q <= 1'b0;
      ok_b_q <= 1'b0;
    end else if (rd_i.en) begin
      ok_a_q <= vld_q[rd_i.addr_a] && (rd_i.addr_a != rcrb_pkg::ZERO_REG);
      ok_b_q <= vld_q[rd_i.addr_b] && (rd_i.addr_b != rcrb_pkg::ZERO_REG);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      data_a_q <= mem[rd_i.addr_a];
      data_b_q <= mem[rd_i.addr_b];
    end
  end

  assign rd_a_o = ok_a_q ? data_a_q : 32'd0;
  assign rd_b_o = ok_b_q ? data_b_q : 32'd0;

endmodule
`default_nettype wire

>>> src/risc_core_with_row_buffer_dram_core.sv
// Channel | Dir | Payload
// req_i   | in  | action, dest_reg, operand_b, operand_c, use_register, target_index, ...
// rsp_o   | out | status, next_pc, dest_value, cycles_total, row_updates
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
// One instruction at a time: register file read, then execute; a load then also
// goes through the data memory read port before it writes back. No new one is taken meanwhile.
// After reset the data memory is zeroed one word per cycle, all MEMORY_BYTES/4 words,
// with req_i.ready low; configuration writes are taken throughout.
// A stalled rsp_o holds the execute stage; one finished result may wait in the output.
`default_nettype none
module risc_core_with_row_buffer_dram_core #(
  parameter int unsigned MEMORY_BYTES = 262144,
  parameter int unsigned ROW_WORDS    = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rcrb_in_if.sink                            req_i,
  rcrb_out_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [rcrb_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned MEM_WORDS = MEMORY_BYTES / 4;
  localparam int unsigned AW        = $clog2(MEM_WORDS);
  localparam int unsigned RSH       = $clog2(ROW_WORDS);
  localparam int unsigned NROWS     = (MEM_WORDS / ROW_WORDS > 1) ? MEM_WORDS / ROW_WORDS : 2;
  localparam int unsigned ROW_W     = $clog2(NROWS);
  localparam logic [31:0] MEM_LIMIT = 32'(MEMORY_BYTES);

  // configuration
  logic [rcrb_pkg::DELAY_W-1:0] row_dly_q, col_dly_q;
  logic [rcrb_pkg::PLEN_W-1:0]  plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_dly_q <= 10'd10;
      col_dly_q <= 10'd2;
      plen_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcrb_pkg::CFG_ROW_DELAY: row_dly_q <= cfg_data_i[rcrb_pkg::DELAY_W-1:0];
        rcrb_pkg::CFG_COL_DELAY: col_dly_q <= cfg_data_i[rcrb_pkg::DELAY_W-1:0];
        rcrb_pkg::CFG_PROG_LEN:  plen_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic x_q, m_q, out_q;
  logic out_free, accept, x_fire, x_load, m_fire;

  assign out_free    = !out_q || rsp_o.ready;
  assign req_i.ready = !clr_q && !x_q && !m_q;
  assign accept      = req_i.valid && req_i.ready;

  // execute stage instruction
  rcrb_pkg::action_e x_act_q;
  logic [4:0]  x_dest_q;
  logic [31:0] x_opb_q, x_opc_q;
  logic        x_use_q, x_def_q;
  logic [15:0] x_tgt_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_act_q  <= rcrb_pkg::action_e'(req_i.action);
      x_dest_q <= req_i.dest_reg;
      x_opb_q  <= req_i.operand_b;
      x_opc_q  <= req_i.operand_c;
      x_use_q  <= req_i.use_register;
      x_tgt_q  <= req_i.target_index;
      x_def_q  <= req_i.target_defined;
    end
  end

  // register file
  rcrb_pkg::rf_rd_t rf_rd;
  rcrb_pkg::rf_wr_t rf_wr;
  logic [31:0] ra, rb;
  logic        b_is_dest;

  assign b_is_dest = (req_i.action == rcrb_pkg::ACT_BEQ) || (req_i.action == rcrb_pkg::ACT_BNE)
                  || (req_i.action == rcrb_pkg::ACT_SW);
  assign rf_rd.en     = accept;
  assign rf_rd.addr_a = req_i.operand_b[4:0];
  assign rf_rd.addr_b = b_is_dest ? req_i.dest_reg : req_i.operand_c[4:0];

  rcrb_regfile u_rf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rf_rd),
    .wr_i   (rf_wr),
    .rd_a_o (ra),
    .rd_b_o (rb)
  );

  // architectural state
  logic [15:0]      pc_q, pc_d;
  logic [31:0]      cyc_q, cyc_d, upd_q, upd_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             open_q, open_d;

  // execute
  logic [1:0]  st;
  logic [31:0] dval, bval, addr, cmp;
  logic        eq, aok, wr_reg, dm_we, dm_re, hit;
  logic [AW-1:0]    w;
  logic [ROW_W-1:0] row_sel;
  logic [11:0]      dly;

  assign bval = (x_use_q && x_act_q != rcrb_pkg::ACT_ADDI) ? rb : x_opc_q;
  assign cmp  = x_use_q ? ra : x_opb_q;
  assign eq   = (rb == cmp);
  assign addr = x_use_q ? ra + x_opc_q : x_opb_q;
  assign aok  = !addr[31] && (addr >= 32'(plen_q)) && (addr < MEM_LIMIT) && (addr[1:0] == 2'b00);
  assign w    = addr[AW+1:2];
  assign row_sel = ROW_W'(w >> RSH);
  assign hit  = open_q && (row_q == row_sel);

  always_comb begin
    st     = rcrb_pkg::ST_OK;
    dval   = 32'd0;
    wr_reg = 1'b0;
    dm_we  = 1'b0;
    dm_re  = 1'b0;
    pc_d   = pc_q;
    cyc_d  = cyc_q;
    upd_d  = upd_q;
    row_d  = row_q;
    open_d = open_q;
    dly    = 12'd0;
    case (x_act_q)
      rcrb_pkg::ACT_ADD, rcrb_pkg::ACT_ADDI, rcrb_pkg::ACT_SUB, rcrb_pkg::ACT_MUL,
      rcrb_pkg::ACT_SLT: begin
        if (x_dest_q == rcrb_pkg::ZERO_REG) begin
          st = rcrb_pkg::ST_ZERO_REG;
        end else begin
          case (x_act_q)
            rcrb_pkg::ACT_SUB: dval = ra - bval;
            rcrb_pkg::ACT_MUL: dval = ra * bval;
            rcrb_pkg::ACT_SLT: dval = {31'd0, $signed(ra) < $signed(bval)};
            default:           dval = ra + bval;
          endcase
          wr_reg = 1'b1;
          pc_d   = pc_q + 16'd1;
          cyc_d  = cyc_q + 32'd1;
        end
      end
      rcrb_pkg::ACT_BEQ, rcrb_pkg::ACT_BNE, rcrb_pkg::ACT_J: begin
        if (!x_def_q) begin
          st = rcrb_pkg::ST_NO_LABEL;
        end else begin
          if (x_act_q == rcrb_pkg::ACT_J || eq == (x_act_q == rcrb_pkg::ACT_BEQ)) begin
            pc_d = x_tgt_q;
          end else begin
            pc_d = pc_q + 16'd1;
          end
          cyc_d = cyc_q + 32'd1;
        end
      end
      rcrb_pkg::ACT_LW, rcrb_pkg::ACT_SW: begin
        if (x_act_q == rcrb_pkg::ACT_LW && x_dest_q == rcrb_pkg::ZERO_REG) begin
          st = rcrb_pkg::ST_ZERO_REG;
        end else if (!aok) begin
          st = rcrb_pkg::ST_BAD_ADDR;
        end else begin
          dly = 12'd1 + 12'(col_dly_q);
          if (!hit) begin
            dly   = dly + (open_q ? {1'b0, row_dly_q, 1'b0} : 12'(row_dly_q));
            row_d = row_sel;
            open_d = 1'b1;
          end
          upd_d = upd_q + 32'(!hit) + 32'(x_act_q == rcrb_pkg::ACT_SW);
          cyc_d = cyc_q + 32'(dly);
          pc_d  = pc_q + 16'd1;
          dm_we = (x_act_q == rcrb_pkg::ACT_SW);
          dm_re = (x_act_q == rcrb_pkg::ACT_LW);
        end
      end
      rcrb_pkg::ACT_FINISH: begin
        if (open_q) begin
          cyc_d  = cyc_q + 32'(row_dly_q);
          open_d = 1'b0;
        end
      end
      default: pc_d = pc_q + 16'd1;
    endcase
  end

  assign x_load = dm_re;
  assign x_fire = x_q && out_free;
  assign m_fire = m_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      cyc_q  <= '0;
      upd_q  <= '0;
      row_q  <= '0;
      open_q <= 1'b0;
    end else if (x_fire) begin
      pc_q   <= pc_d;
      cyc_q  <= cyc_d;
      upd_q  <= upd_d;
      row_q  <= row_d;
      open_q <= open_d;
    end
  end

  // data memory
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] dm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      dmem[clr_cnt_q] <= 32'd0;
    end else if (x_fire && dm_we) begin
      dmem[w] <= rb;
    end
    if (x_fire && dm_re) begin
      dm_rdata_q <= dmem[w];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // load write-back stage
  logic [4:0] m_dest_q;

  always_ff @(posedge clk_i) begin
    if (x_fire && x_load) begin
      m_dest_q <= x_dest_q;
    end
  end

  always_comb begin
    rf_wr.en   = 1'b0;
    rf_wr.addr = x_dest_q;
    rf_wr.data = dval;
    if (m_fire) begin
      rf_wr.en   = 1'b1;
      rf_wr.addr = m_dest_q;
      rf_wr.data = dm_rdata_q;
    end else if (x_fire && wr_reg) begin
      rf_wr.en = 1'b1;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= 1'b0;
      m_q   <= 1'b0;
      out_q <= 1'b0;
    end else begin
      if (accept) begin
        x_q <= 1'b1;
      end else if (x_fire) begin
        x_q <= 1'b0;
      end
      if (x_fire && x_load) begin
        m_q <= 1'b1;
      end else if (m_fire) begin
        m_q <= 1'b0;
      end
      if ((x_fire && !x_load) || m_fire) begin
        out_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_q <= 1'b0;
      end
    end
  end

  // output register
  logic [1:0]  o_st_q;
  logic [15:0] o_pc_q;
  logic [31:0] o_dv_q, o_cyc_q, o_upd_q;

  always_ff @(posedge clk_i) begin
    if (x_fire) begin
      o_st_q  <= st;
      o_pc_q  <= pc_d;
      o_dv_q  <= dval;
      o_cyc_q <= cyc_d;
      o_upd_q <= upd_d;
    end else if (m_fire) begin
      o_dv_q  <= dm_rdata_q;
    end
  end

  assign rsp_o.valid        = out_q;
  assign rsp_o.status       = o_st_q;
  assign rsp_o.next_pc      = o_pc_q;
  assign rsp_o.dest_value   = o_dv_q;
  assign rsp_o.cycles_total = o_cyc_q;
  assign rsp_o.row_updates  = o_upd_q;

endmodule
`default_nettype wire
